>>> rtl/core/suffix_array_nearest_smaller_scan_macros.svh
// assertion macros for the nearest smaller scan checker
`ifndef SUFFIX_ARRAY_NEAREST_SMALLER_SCAN_MACROS_SVH
`define SUFFIX_ARRAY_NEAREST_SMALLER_SCAN_MACROS_SVH

// checked only outside reset
`define SANSV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define SANSV_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/sansv_pkg.sv
package sansv_pkg;

  localparam int POS_W    = 12;
  localparam int POS_SPAN = 4096;

  typedef logic [POS_W-1:0] pos_t;

  typedef enum logic {
    CMD_FEED,
    CMD_READ
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    pos_t      pos;
    logic      last;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_RDWAIT
  } eng_state_t;

endpackage

>>> rtl/core/sansv_ram.sv
module sansv_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/sansv_front.sv
module sansv_front
  import sansv_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic in_mode,
  input  pos_t in_sa_entry,
  input  logic in_is_last,
  input  pos_t in_read_position,
  output logic cmd_valid,
  input  logic cmd_ready,
  output cmd_t cmd
);

  cmd_t       slot_r [2];
  cmd_t       incoming;
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       push, pop;

  // classify the incoming word
  always_comb begin
    incoming.kind = in_mode ? CMD_READ : CMD_FEED;
    incoming.pos  = in_mode ? in_read_position : in_sa_entry;
    incoming.last = in_is_last & ~in_mode;
  end

  assign in_ready  = (fill_r != 2'd2);
  assign cmd_valid = (fill_r != 2'd0);
  assign cmd       = slot_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 2'd1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= incoming;
    end
  end

endmodule

>>> rtl/core/sansv_engine.sv
module sansv_engine
  import sansv_pkg::*;
#(
  parameter int MAX_LEN = 4096
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic out_valid,
  input  logic out_ready,
  output pos_t out_position,
  output pos_t out_match_position
);

  localparam int TBL_DEPTH = (MAX_LEN < POS_SPAN) ? MAX_LEN : POS_SPAN;
  localparam int TAW       = $clog2(TBL_DEPTH);
  localparam int CW        = $clog2(TBL_DEPTH + 1);

  eng_state_t    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] st_rd_count;
  pos_t          top_r, top_nxt;
  cmd_t          cur_r;
  logic          out_valid_r, out_valid_nxt;
  pos_t          out_pos_r, out_match_r;

  logic           pop_en, push_en, load_out, take_cmd;
  logic           mt_we;
  logic [TAW-1:0] mt_waddr, mt_raddr;
  pos_t           mt_wdata, mt_rdata;
  pos_t           st_rdata, rd_pos;
  logic           cmp_pop, stack_full, slot_free, top_in_tbl, rd_in_tbl;

  assign cmp_pop    = (count_r != '0) && (top_r >= cur_r.pos);
  assign stack_full = (count_r == CW'(TBL_DEPTH));
  assign slot_free  = !out_valid_r || out_ready;
  assign top_in_tbl = (32'(top_r) < 32'(TBL_DEPTH));
  assign rd_pos     = (state_r == ST_RDWAIT) ? cur_r.pos : cmd.pos;
  assign rd_in_tbl  = (32'(cur_r.pos) < 32'(TBL_DEPTH));
  assign mt_raddr   = rd_pos[TAW-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          state_nxt = (cmd.kind == CMD_READ) ? ST_RDWAIT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!cmp_pop) begin
          state_nxt = cur_r.last ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (count_r <= CW'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RDWAIT: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    take_cmd = 1'b0;
    pop_en   = 1'b0;
    push_en  = 1'b0;
    load_out = 1'b0;
    mt_we    = 1'b0;
    mt_wdata = cur_r.pos;
    case (state_r)
      ST_IDLE: begin
        take_cmd = 1'b1;
      end
      ST_SCAN: begin
        if (cmp_pop) begin
          pop_en = 1'b1;
          mt_we  = top_in_tbl;
        end else begin
          push_en = !stack_full;
        end
      end
      ST_FLUSH: begin
        if (count_r != '0) begin
          pop_en   = 1'b1;
          mt_we    = top_in_tbl;
          mt_wdata = '0;
        end
      end
      ST_RDWAIT: begin
        load_out = slot_free;
      end
      default: begin
        take_cmd = 1'b0;
      end
    endcase
  end

  assign cmd_ready = take_cmd;
  assign mt_waddr  = top_r[TAW-1:0];

  always_comb begin
    count_nxt = count_r;
    top_nxt   = top_r;
    if (pop_en) begin
      count_nxt = count_r - CW'(1);
      top_nxt   = st_rdata;
    end else if (push_en) begin
      count_nxt = count_r + CW'(1);
      top_nxt   = cur_r.pos;
    end
  end

  // keep the word under the top prefetched
  assign st_rd_count = count_nxt - CW'(2);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    if (take_cmd && cmd_valid) begin
      cur_r <= cmd;
    end
    if (load_out) begin
      out_pos_r   <= cur_r.pos;
      out_match_r <= rd_in_tbl ? mt_rdata : '0;
    end
  end

  sansv_ram #(
    .WIDTH (POS_W),
    .DEPTH (TBL_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (push_en),
    .waddr (count_r[TAW-1:0]),
    .wdata (cur_r.pos),
    .raddr (st_rd_count[TAW-1:0]),
    .rdata (st_rdata)
  );

  sansv_ram #(
    .WIDTH (POS_W),
    .DEPTH (TBL_DEPTH)
  ) u_match_ram (
    .clk   (clk),
    .we    (mt_we),
    .waddr (mt_waddr),
    .wdata (mt_wdata),
    .raddr (mt_raddr),
    .rdata (mt_rdata)
  );

  assign out_valid          = out_valid_r;
  assign out_position       = out_pos_r;
  assign out_match_position = out_match_r;

endmodule

>>> rtl/core/suffix_array_nearest_smaller_scan.sv
// All nearest smaller values over a suffix array. Feed words (in_mode 0) carry the
// text positions in suffix order; each pops every pending position not below it,
// records it as their match, then is pushed; the word flagged in_is_last then
// flushes the stack, recording 0 for what is left. Read words (in_mode 1) return
// the recorded match of in_read_position, 0 for positions at or above MAX_LEN, and
// 0 also stands for no match; a read of a position never recorded returns
// undefined data. Words enter a two-entry queue and are executed by one
// sequencer over a stack RAM and a match RAM: a feed word pops the positions it
// covers one by one before it is pushed (the last word then pops, one by one,
// each position left in the flush), and a read word waits for the output register
// to be free. No clearing pass after reset is needed.
module suffix_array_nearest_smaller_scan
  import sansv_pkg::*;
#(
  parameter int MAX_LEN = 4096
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic in_mode,
  input  pos_t in_sa_entry,
  input  logic in_is_last,
  input  pos_t in_read_position,
  output logic out_valid,
  input  logic out_ready,
  output pos_t out_position,
  output pos_t out_match_position
);

  cmd_t cmd;
  logic cmd_valid, cmd_ready;

  sansv_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_sa_entry      (in_sa_entry),
    .in_is_last       (in_is_last),
    .in_read_position (in_read_position),
    .cmd_valid        (cmd_valid),
    .cmd_ready        (cmd_ready),
    .cmd              (cmd)
  );

  sansv_engine #(
    .MAX_LEN (MAX_LEN)
  ) u_engine (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd_valid          (cmd_valid),
    .cmd_ready          (cmd_ready),
    .cmd                (cmd),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_position       (out_position),
    .out_match_position (out_match_position)
  );

endmodule

>>> rtl/core/sansv_checker.sv
`include "suffix_array_nearest_smaller_scan_macros.svh"

module sansv_checker
  import sansv_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input pos_t out_position,
  input pos_t out_match_position
);

  logic [2*POS_W-1:0] out_word;

  assign out_word = {out_position, out_match_position};

  // a result word waits until taken
  `SANSV_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result word dropped")
  `SANSV_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_word), "word changed")
  // reset empties the queue and the output register
  `SANSV_ASSERT_ANY(a_reset_clear, !rst_n |=> !out_valid && in_ready, "reset left state behind")
  // the queue only fills on an accepted word
  `SANSV_ASSERT(a_ready_fall, $fell(in_ready) |-> $past(in_valid && in_ready), "no word taken")

endmodule

bind suffix_array_nearest_smaller_scan sansv_checker u_chk (.*);
